// ===== rtl/first_fit_block_allocator_macros.svh =====
// Assertion macros for the first-fit block allocator.
// Used by the top level only.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Implication checked at every clock edge, skipped while reset is high.
`define FFA_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Implication whose result is checked in the following cycle.
`define FFA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== rtl/ffa_pkg.sv =====
// Package for the first-fit block allocator: sizes, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int PoolBytes   = 1048576;
  localparam int HeaderBytes = 24;
  localparam int MaxBlocks   = 64;
  localparam int AW = 21;
  localparam int IW = $clog2(MaxBlocks);
  localparam int CW = $clog2(MaxBlocks + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // One table entry: header offset, payload size, free flag.
  typedef struct packed {
    logic [AW-1:0] offset;
    logic [AW-1:0] size;
    logic          free;
  } entry_t;
endpackage

// ===== rtl/ffa_table.sv =====
// Block table memory: one write port, one registered read port.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
module ffa_table
  import ffa_pkg::*;
(
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [MaxBlocks];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit block allocator: top level with sequencer and shared adder.
// Depends on ffa_pkg, ffa_table and first_fit_block_allocator_macros.svh.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_axis: tuser holds cmd (0 allocate, 1 free); tdata holds
//   request_size [20:0] and free_address [41:21], upper bits zero.
//   Output channel m_axis: tdata holds status [1:0], payload_address [22:2],
//   granted_size [43:23]. One result word per input word.
//   Items are handled one at a time; s_axis_tready is low while busy.
//   Timing: the table is read one entry at a time through its single
//   registered read port. A zero-size request shows its result in the cycle
//   after acceptance; other requests scan entries from 0 up to the hit, and
//   a miss scans all count entries. A split moves each later entry up one
//   place, then writes the new free entry. A merge reads each absorbed block
//   and moves the entries behind it down, so freeing entry 0 ahead of 63
//   free blocks is the slowest case.
//   Reset: the table is seeded with one free block over the pool
//   (entry 0 only; entries past the count are never read).
//   The result sits in an output register; when the receiver stalls it
//   holds, and the next input word is taken only after it leaves.
module first_fit_block_allocator
  import ffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // request_size, free_address
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status, payload_address, granted_size
);
`include "first_fit_block_allocator_macros.svh"

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_SPLIT_RD, S_SPLIT_WR, S_SPLIT_DONE,
    S_MRG_RD, S_MRG_CHK, S_SH_RD, S_SH_WR, S_OUT
  } state_t;

  state_t        state;
  logic          cmd;
  logic [AW:0]   req_need;
  logic [AW-1:0] faddr;
  logic [IW-1:0] idx;
  logic [IW-1:0] hit;
  logic [CW-1:0] count;
  entry_t        cur;
  logic [AW:0]   acc;
  logic [1:0]    st;
  logic [AW-1:0] paddr;
  logic [AW-1:0] gsize;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  ffa_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Shared adder: one operand pair per state.
  logic [AW:0] add_a, add_b, add_sum;
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state)
      S_CHK:     begin add_a = {1'b0, rdata.offset}; add_b = (AW+1)'(HeaderBytes); end
      S_MRG_CHK: begin add_a = acc; add_b = {1'b0, rdata.size} + (AW+1)'(HeaderBytes); end
      default: ;
    endcase
    add_sum = add_a + add_b;
  end

  logic [AW:0] in_need;
  assign in_need = ({1'b0, s_axis_tdata[AW-1:0]} + (AW+1)'(7)) & ~(AW+1)'(7);

  logic [AW:0] left;
  assign left = {1'b0, rdata.size} - req_need;
  logic last_entry;
  assign last_entry = ({1'b0, idx} + 1'b1) >= count;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = cur;
    raddr = idx;
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{offset: '0, size: AW'(PoolBytes - HeaderBytes), free: 1'b1};
      end
      S_CHK: begin
        if (cmd == CMD_ALLOC && rdata.free && {1'b0, rdata.size} >= req_need) begin
          we    = 1'b1;
          wdata = rdata;
          wdata.free = 1'b0;
          if (left > (AW+1)'(HeaderBytes + 8) && count < CW'(MaxBlocks)) begin
            wdata.size = req_need[AW-1:0];
          end
        end else if (cmd == CMD_FREE && add_sum == {1'b0, faddr}) begin
          we    = 1'b1;
          wdata = rdata;
          wdata.free = 1'b1;
        end
      end
      S_SPLIT_RD: raddr = idx - 1'b1;
      S_SPLIT_WR: begin we = 1'b1; wdata = rdata; end
      S_SPLIT_DONE: begin we = 1'b1; wdata = cur; end
      S_SH_RD: raddr = idx + 1'b1;
      S_SH_WR: begin we = 1'b1; wdata = rdata; end
      S_OUT: if (m_axis_tready && cmd == CMD_FREE && st == ST_OK) begin
        we = 1'b1; waddr = hit; wdata = cur;
        wdata.size = acc[AW-1:0]; wdata.free = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= CW'(1);
    end else begin
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: if (s_axis_tvalid) begin
          cmd      <= s_axis_tuser;
          req_need <= in_need;
          faddr    <= s_axis_tdata[2*AW-1:AW];
          idx      <= '0;
          paddr    <= '0;
          gsize    <= '0;
          if (s_axis_tuser == CMD_ALLOC && s_axis_tdata[AW-1:0] == '0) begin
            st <= ST_ZERO; state <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (cmd == CMD_ALLOC && rdata.free && {1'b0, rdata.size} >= req_need) begin
            st    <= ST_OK;
            paddr <= add_sum[AW-1:0];
            if (left > (AW+1)'(HeaderBytes + 8) && count < CW'(MaxBlocks)) begin
              gsize      <= req_need[AW-1:0];
              hit        <= idx;
              cur.offset <= rdata.offset + AW'(HeaderBytes) + req_need[AW-1:0];
              cur.size   <= AW'(left - (AW+1)'(HeaderBytes));
              cur.free   <= 1'b1;
              idx        <= count[IW-1:0];
              state      <= (count[IW-1:0] == idx + 1'b1) ? S_SPLIT_DONE : S_SPLIT_RD;
            end else begin
              gsize <= rdata.size;
              state <= S_OUT;
            end
          end else if (cmd == CMD_FREE && add_sum == {1'b0, faddr}) begin
            st  <= ST_OK;
            hit <= idx;
            cur <= rdata;
            acc <= {1'b0, rdata.size};
            if (last_entry) begin
              gsize <= rdata.size; state <= S_OUT;
            end else begin
              idx <= idx + 1'b1; state <= S_MRG_RD;
            end
          end else if (last_entry) begin
            st    <= (cmd == CMD_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
            state <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        // Shift entries up from the end down to hit+2.
        S_SPLIT_RD: state <= S_SPLIT_WR;
        S_SPLIT_WR: begin
          idx   <= idx - 1'b1;
          state <= (idx - 1'b1 == hit + 1'b1) ? S_SPLIT_DONE : S_SPLIT_RD;
        end
        S_SPLIT_DONE: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end
        // idx points at the entry after hit; merge while it is free.
        S_MRG_RD: state <= S_MRG_CHK;
        S_MRG_CHK: begin
          if (rdata.free) begin
            acc   <= {1'b0, add_sum[AW-1:0]};
            count <= count - 1'b1;
            if ({1'b0, idx} + 1'b1 >= count) begin
              gsize <= add_sum[AW-1:0]; state <= S_OUT;
            end else begin
              state <= S_SH_RD;
            end
          end else begin
            gsize <= acc[AW-1:0];
            state <= S_OUT;
          end
        end
        // Remove entry hit+1 by moving the rest down; count already dropped.
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if ({1'b0, idx} + 1'b1 >= count) begin
            idx   <= hit + 1'b1;
            state <= ({1'b0, hit} + 2'd2 > count) ? S_OUT : S_MRG_RD;
            if ({1'b0, hit} + 2'd2 > count) gsize <= acc[AW-1:0];
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SH_RD;
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {4'b0, gsize, paddr, st};

  `FFA_ASSERT_IMP(a_no_overlap, clk, rst, s_axis_tready, !m_axis_tvalid,
    "input and output both open")
  `FFA_ASSERT_IMP(a_count_range, clk, rst, 1'b1,
    count != '0 && count <= CW'(MaxBlocks), "block count out of range")
  `FFA_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
endmodule

// ===== verif/first_fit_block_allocator_tb.sv =====
// Testbench for the first-fit block allocator: drives allocate and free words,
// predicts each result with its own block table and compares field by field.
// Depends on ffa_pkg and the first_fit_block_allocator top level.
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;
  import ffa_pkg::*;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [AW-1:0] req_size;
    logic          cmd;
  } alloc_req_t;

  typedef struct packed {
    logic [AW-1:0] gsize;
    logic [AW-1:0] payload;
    logic [1:0]    status;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Block table mirror
  logic [AW-1:0] tbl_off  [MaxBlocks];
  logic [AW-1:0] tbl_size [MaxBlocks];
  logic          tbl_free [MaxBlocks];
  int            tbl_count;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  logic [AW-1:0] live_addrs[$];   // payload offsets the stimulus believes are held
  int  errors = 0;
  int  n_ok = 0, n_nofit = 0, n_zero = 0, n_unknown = 0, n_rsp = 0;
  longint cycles = 0;
  bit  quiet = 1'b0;
  int  src_idle = 0, snk_idle = 0;

  function automatic void table_reset();
    for (int k = 0; k < MaxBlocks; k++) begin
      tbl_off[k] = '0; tbl_size[k] = '0; tbl_free[k] = 1'b0;
    end
    tbl_size[0] = AW'(PoolBytes - HeaderBytes);
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic alloc_rsp_t predict_allocation(alloc_req_t r);
    alloc_rsp_t o;
    longint need, left;
    o = '0;
    if (r.cmd == CMD_ALLOC) begin
      if (r.req_size == 0) begin
        o.status = ST_ZERO;
        return o;
      end
      need = (longint'(r.req_size) + 7) & ~longint'(7);
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_free[i] && longint'(tbl_size[i]) >= need) begin
          left = longint'(tbl_size[i]) - need;
          if (left > HeaderBytes + 8 && tbl_count < MaxBlocks) begin
            for (int j = tbl_count; j > i + 1; j--) begin
              tbl_off[j] = tbl_off[j-1]; tbl_size[j] = tbl_size[j-1];
              tbl_free[j] = tbl_free[j-1];
            end
            tbl_off[i+1]  = AW'(longint'(tbl_off[i]) + HeaderBytes + need);
            tbl_size[i+1] = AW'(left - HeaderBytes);
            tbl_free[i+1] = 1'b1;
            tbl_size[i]   = AW'(need);
            tbl_count++;
          end
          tbl_free[i] = 1'b0;
          o.status  = ST_OK;
          o.payload = AW'(longint'(tbl_off[i]) + HeaderBytes);
          o.gsize   = tbl_size[i];
          return o;
        end
      end
      o.status = ST_NO_FIT;
      return o;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (longint'(tbl_off[i]) + HeaderBytes == longint'(r.addr)) begin
        tbl_free[i] = 1'b1;
        // absorb following free blocks
        while (i + 1 < tbl_count && tbl_free[i+1]) begin
          tbl_size[i] = AW'(longint'(tbl_size[i]) + HeaderBytes + tbl_size[i+1]);
          for (int j = i + 1; j + 1 < tbl_count; j++) begin
            tbl_off[j] = tbl_off[j+1]; tbl_size[j] = tbl_size[j+1];
            tbl_free[j] = tbl_free[j+1];
          end
          tbl_count--;
          tbl_off[tbl_count] = '0; tbl_size[tbl_count] = '0;
          tbl_free[tbl_count] = 1'b0;
        end
        o.status = ST_OK;
        o.gsize  = tbl_size[i];
        return o;
      end
    end
    o.status = ST_UNKNOWN;
    return o;
  endfunction

  task automatic push_alloc(int sz);
    alloc_req_t r;
    r = '0; r.cmd = CMD_ALLOC; r.req_size = AW'(sz); r.addr = AW'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic push_free(int a);
    alloc_req_t r;
    r = '0; r.cmd = CMD_FREE; r.addr = AW'(a); r.req_size = AW'($urandom);
    pending_reqs.push_back(r);
  endtask

  // Driver
  always @(posedge clk) begin
    alloc_req_t r;
    alloc_rsp_t e;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = '0;
        r.cmd      = s_axis_tuser;
        r.req_size = s_axis_tdata[AW-1:0];
        r.addr     = s_axis_tdata[2*AW-1:AW];
        e = predict_allocation(r);
        expected_rsps.push_back(e);
        if (r.cmd == CMD_ALLOC && e.status == ST_OK) live_addrs.push_back(e.payload);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_idle > 0) begin
          src_idle <= src_idle - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          s_axis_tdata  <= {6'b0, r.addr, r.req_size};
          s_axis_tuser  <= r.cmd;
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) src_idle <= $urandom_range(1, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and sink
  always @(posedge clk) begin
    alloc_rsp_t got, e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = alloc_rsp_t'(m_axis_tdata[43:0]);
        n_rsp++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          case (e.status)
            ST_OK:     n_ok++;
            ST_NO_FIT: n_nofit++;
            ST_ZERO:   n_zero++;
            default:   n_unknown++;
          endcase
          if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
          end
          if (got.payload !== e.payload) begin
            $display("%0t: payload_address expected %0d actual %0d", $time,
                     e.payload, got.payload);
            errors++;
          end
          if (got.gsize !== e.gsize) begin
            $display("%0t: granted_size expected %0d actual %0d", $time,
                     e.gsize, got.gsize);
            errors++;
          end
        end
      end
      if (snk_idle > 0) begin
        snk_idle <= snk_idle - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 11) == 0) snk_idle <= $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("** first_fit_block_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    int k, sz, pick;
    table_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero size, extremes, unknown addresses, split and merge cases
    push_alloc(0);
    push_alloc(1);                            // rounds to 8
    push_alloc(8);
    push_alloc(2097151);                      // all ones, no fit
    push_alloc(1048576);                      // larger than pool payload
    push_free(0);                             // unknown
    push_free(2097151);                       // unknown, all ones
    push_free(HeaderBytes + 1);               // unknown, off by one
    push_free(HeaderBytes);                   // first block
    push_free(HeaderBytes);                   // free of a free block
    push_alloc(PoolBytes - HeaderBytes);      // whole pool payload; no fit, a block is still held
    push_alloc(1);                            // fits the freed first block
    push_free(HeaderBytes);
    push_alloc(PoolBytes - 2 * HeaderBytes - 8 - 8); // header+8+8 under pool payload; no fit
    push_free(HeaderBytes);
    push_alloc(PoolBytes - 2 * HeaderBytes - 8);     // header+8 under pool payload; no fit
    push_free(HeaderBytes);
    push_alloc(1365);
    push_alloc(1366);
    push_free(HeaderBytes);
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (300) @(posedge clk);

    // Fill the table with small blocks so that the full-table case comes up
    for (k = 0; k < 70; k++) push_alloc($urandom_range(1, 64));
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);

    // Random: mostly frees of held blocks and allocations of mixed sizes
    for (k = 0; k < 820; k++) begin
      if (k == 700) quiet = 1'b1;
      wait (pending_reqs.size() < 2);
      pick = $urandom_range(0, 99);
      if (pick < 45 && live_addrs.size() > 0) begin
        sz = $urandom_range(0, live_addrs.size() - 1);
        push_free(live_addrs[sz]);
        live_addrs.delete(sz);
      end else if (pick < 50) begin
        push_free($urandom_range(0, 2097151));
      end else if (pick < 52) begin
        push_alloc(0);
      end else if (pick < 55) begin
        push_alloc($urandom_range(0, 2097151));
      end else if (pick < 60) begin
        push_alloc($urandom_range(1, 300000));
      end else begin
        push_alloc($urandom_range(1, 4096));
      end
      @(posedge clk);
    end

    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    k = 0;
    while (expected_rsps.size() != 0 && k < 200000) begin
      @(posedge clk);
      k++;
    end
    repeat (400) @(posedge clk);
    $display("Results checked: %0d (ok %0d, no fit %0d, zero size %0d, unknown free %0d)",
             n_rsp, n_ok, n_nofit, n_zero, n_unknown);
    $display("Leftover expectations: %0d, mismatches: %0d", expected_rsps.size(), errors);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("** first_fit_block_allocator: PASSED **");
    end else begin
      $display("** first_fit_block_allocator: FAILED **");
    end
    $finish;
  end
endmodule
